>>> rtl/emg_pkg.sv
// Shared types, codes and constants of the easing motion generator.
package emg_pkg;

    localparam int FRAC_BITS = 16;

    // Divider quotient width: every quotient stays at or below 2^(FRAC_BITS+1).
    localparam int QW       = FRAC_BITS + 2;
    // Square root operand and steps.
    localparam int SQW      = QW + FRAC_BITS;
    localparam int SQ_STEPS = (SQW + 1) / 2;
    // Curve factor width (two-phase gain path peaks near 8 * 2^FRAC_BITS).
    localparam int FW       = FRAC_BITS + 6;
    // round(1.2 * 2^FRAC_BITS)
    localparam int K_ONE_POINT_TWO = (6 * (2 ** FRAC_BITS) + 2) / 5;
    localparam int GAIN_FRAC = 12;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PLAY = 2'd1;
    localparam logic [1:0] OP_STOP = 2'd2;

    localparam logic [1:0] KIND_TICK = 2'd0;
    localparam logic [1:0] KIND_PLAY = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    localparam logic [1:0] MODE_LINEAR   = 2'd0;
    localparam logic [1:0] MODE_EASE_IN  = 2'd1;
    localparam logic [1:0] MODE_EASE_OUT = 2'd2;
    localparam logic [1:0] MODE_TWO_PH   = 2'd3;

    localparam logic [2:0] REG_START_X  = 3'd0;
    localparam logic [2:0] REG_START_Y  = 3'd1;
    localparam logic [2:0] REG_END_X    = 3'd2;
    localparam logic [2:0] REG_END_Y    = 3'd3;
    localparam logic [2:0] REG_DURATION = 3'd4;
    localparam logic [2:0] REG_CURVE    = 3'd5;
    localparam logic [2:0] REG_GAIN     = 3'd6;

    localparam logic [31:0] DURATION_RST = 32'd1000000;
    localparam logic [15:0] GAIN_RST     = 16'd4096;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] delta_us;
    } item_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic               playing;
        logic               finished;
    } result_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] delta_us;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] start_x;
        logic signed [31:0] start_y;
        logic signed [31:0] end_x;
        logic signed [31:0] end_y;
        logic [31:0]        duration_us;
        logic [1:0]         curve_mode;
        logic [15:0]        end_speed_gain;
    } cfg_t;

endpackage

>>> rtl/emg_regs.sv
// APB-style configuration register file.
module emg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output emg_pkg::cfg_t      cfg
);

    emg_pkg::cfg_t cfg_reg;
    logic          wr_en;
    logic [2:0]    idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[4:2];
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_x        <= '0;
            cfg_reg.start_y        <= '0;
            cfg_reg.end_x          <= '0;
            cfg_reg.end_y          <= '0;
            cfg_reg.duration_us    <= emg_pkg::DURATION_RST;
            cfg_reg.curve_mode     <= emg_pkg::MODE_LINEAR;
            cfg_reg.end_speed_gain <= emg_pkg::GAIN_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                emg_pkg::REG_START_X:  cfg_reg.start_x        <= pwdata;
                emg_pkg::REG_START_Y:  cfg_reg.start_y        <= pwdata;
                emg_pkg::REG_END_X:    cfg_reg.end_x          <= pwdata;
                emg_pkg::REG_END_Y:    cfg_reg.end_y          <= pwdata;
                emg_pkg::REG_DURATION: cfg_reg.duration_us    <= pwdata;
                emg_pkg::REG_CURVE:    cfg_reg.curve_mode     <= pwdata[1:0];
                emg_pkg::REG_GAIN:     cfg_reg.end_speed_gain <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            emg_pkg::REG_START_X:  prdata = cfg_reg.start_x;
            emg_pkg::REG_START_Y:  prdata = cfg_reg.start_y;
            emg_pkg::REG_END_X:    prdata = cfg_reg.end_x;
            emg_pkg::REG_END_Y:    prdata = cfg_reg.end_y;
            emg_pkg::REG_DURATION: prdata = cfg_reg.duration_us;
            emg_pkg::REG_CURVE:    prdata = {30'd0, cfg_reg.curve_mode};
            emg_pkg::REG_GAIN:     prdata = {16'd0, cfg_reg.end_speed_gain};
            default:               prdata = '0;
        endcase
    end

endmodule

>>> rtl/emg_front.sv
// Front end: decodes input beats and queues them for the engine.
module emg_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    output logic           full,
    input  emg_pkg::item_t item,
    output logic           cmd_valid,
    output emg_pkg::cmd_t  cmd,
    input  logic           cmd_take
);

    emg_pkg::cmd_t q_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          do_push;
    logic          do_pop;
    emg_pkg::cmd_t dec;

    always_comb
    begin
        dec.delta_us = item.delta_us;
        unique case (item.operation)
            emg_pkg::OP_TICK: dec.kind = emg_pkg::KIND_TICK;
            emg_pkg::OP_PLAY: dec.kind = emg_pkg::KIND_PLAY;
            emg_pkg::OP_STOP: dec.kind = emg_pkg::KIND_STOP;
            default:          dec.kind = emg_pkg::KIND_NONE;
        endcase
    end

    assign full      = (count_reg == 2'd2);
    assign cmd_valid = (count_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push & ~full;
    assign do_pop    = cmd_take & cmd_valid;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

>>> rtl/emg_engine.sv
// Back end: motion state, shared divider, square root and position update.
module emg_engine (
    input  logic             clk,
    input  logic             rst_n,
    input  emg_pkg::cfg_t    cfg,
    input  logic             cmd_valid,
    input  emg_pkg::cmd_t    cmd,
    output logic             cmd_take,
    output emg_pkg::result_t result,
    output logic             empty,
    input  logic             pop
);

    localparam int Q  = emg_pkg::FRAC_BITS;
    localparam int PW = 33 + emg_pkg::FW + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_NEXT = 3'd2;
    localparam logic [2:0] ST_SQR  = 3'd3;
    localparam logic [2:0] ST_SQRT = 3'd4;
    localparam logic [2:0] ST_KMUL = 3'd5;
    localparam logic [2:0] ST_GMUL = 3'd6;
    localparam logic [2:0] ST_MUL  = 3'd7;

    localparam logic [2:0] PATH_LIN = 3'd0;
    localparam logic [2:0] PATH_IN  = 3'd1;
    localparam logic [2:0] PATH_OUT = 3'd2;
    localparam logic [2:0] PATH_PH1 = 3'd3;
    localparam logic [2:0] PATH_PH2 = 3'd4;

    localparam logic [emg_pkg::QW-1:0] Q_ONE = emg_pkg::QW'(1) << Q;
    localparam logic [emg_pkg::SQ_STEPS-1:0] S_ONE = emg_pkg::SQ_STEPS'(1) << Q;
    localparam logic [Q+1:0] K_CONST = (Q+2)'(emg_pkg::K_ONE_POINT_TWO);
    localparam logic [emg_pkg::SQW-1:0] BIT0 =
        emg_pkg::SQW'(1) << (2 * (emg_pkg::SQ_STEPS - 1));

    function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] hi;
        logic signed [PW-1:0] lo;
        hi = $signed({{(PW-32){1'b0}}, 32'h7fffffff});
        lo = $signed({{(PW-32){1'b1}}, 32'h80000000});
        if (v > hi)
            return 32'sh7fffffff;
        else if (v < lo)
            return 32'sh80000000;
        else
            return v[31:0];
    endfunction

    logic [2:0]               state_reg;
    logic [2:0]               path_reg;
    logic [4:0]               cnt_reg;
    logic [31:0]              elapsed_reg;
    logic                     running_reg;
    logic signed [31:0]       cur_x_reg;
    logic signed [31:0]       cur_y_reg;
    logic signed [32:0]       dx_reg;
    logic signed [32:0]       dy_reg;
    logic signed [32:0]       base_x_reg;
    logic signed [32:0]       base_y_reg;
    logic [31:0]              den_reg;
    logic [31:0]              rem_reg;
    logic [emg_pkg::QW-1:0]   low_reg;
    logic [emg_pkg::QW-1:0]   quo_reg;
    logic [emg_pkg::SQW-1:0]  sq_v_reg;
    logic [emg_pkg::SQW-1:0]  sq_res_reg;
    logic [emg_pkg::SQW-1:0]  sq_bit_reg;
    logic [emg_pkg::SQ_STEPS-1:0] e_reg;
    logic [emg_pkg::SQ_STEPS+1:0] e1_reg;
    logic [emg_pkg::FW-1:0]   f_reg;
    logic signed [PW-1:0]     prod_x_reg;
    logic signed [PW-1:0]     prod_y_reg;
    emg_pkg::result_t         res_reg;
    logic                     res_valid_reg;

    // tick arithmetic
    logic [31:0]        dur;
    logic [31:0]        half;
    logic [32:0]        t_sum;
    logic [31:0]        t_sat;
    logic               ph1;
    logic               two_ph;
    logic               base_mid;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] sx;
    logic signed [32:0] sy;
    logic signed [32:0] mid_x;
    logic signed [32:0] mid_y;
    logic               take;

    // iterative units
    logic [32:0]              trial;
    logic                     trial_ge;
    logic [emg_pkg::SQW-1:0]  sq_sum;
    logic [2*emg_pkg::QW-1:0] sq_prod;
    logic [emg_pkg::SQ_STEPS+Q+1:0] k_prod;
    logic [emg_pkg::SQ_STEPS+17:0]  g_prod;
    logic [emg_pkg::SQ_STEPS-1:0]   s_val;
    logic signed [PW-1:0]     sum_x;
    logic signed [PW-1:0]     sum_y;

    assign dur   = (cfg.duration_us == 32'd0) ? 32'd1 : cfg.duration_us;
    assign half  = dur >> 1;
    assign t_sum = {1'b0, elapsed_reg} + {1'b0, cmd.delta_us};
    assign t_sat = t_sum[32] ? 32'hffffffff : t_sum[31:0];
    assign two_ph = (cfg.curve_mode == emg_pkg::MODE_TWO_PH);
    assign ph1   = two_ph && (elapsed_reg < half);
    // midpoint base: half-time snap and phase two
    assign base_mid = two_ph && !(ph1 && (t_sat < half));
    assign sx    = {cfg.start_x[31], cfg.start_x};
    assign sy    = {cfg.start_y[31], cfg.start_y};
    assign dx    = {cfg.end_x[31], cfg.end_x} - sx;
    assign dy    = {cfg.end_y[31], cfg.end_y} - sy;
    assign mid_x = sx + (dx >>> 1);
    assign mid_y = sy + (dy >>> 1);

    assign take     = (state_reg == ST_IDLE) && cmd_valid && !res_valid_reg;
    assign cmd_take = take;

    assign trial    = {rem_reg, low_reg[emg_pkg::QW-1]};
    assign trial_ge = trial >= {1'b0, den_reg};
    assign sq_sum   = sq_res_reg + sq_bit_reg;
    assign sq_prod  = quo_reg * quo_reg;
    assign k_prod   = e_reg * K_CONST;
    assign g_prod   = e1_reg * cfg.end_speed_gain;
    assign s_val    = sq_res_reg[emg_pkg::SQ_STEPS-1:0];

    // floor shift of signed product is an arithmetic shift
    assign sum_x = PW'(base_x_reg) + (prod_x_reg >>> Q);
    assign sum_y = PW'(base_y_reg) + (prod_y_reg >>> Q);

    assign result = res_reg;
    assign empty  = !res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            path_reg      <= PATH_LIN;
            cnt_reg       <= '0;
            elapsed_reg   <= '0;
            running_reg   <= 1'b0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            dx_reg        <= '0;
            dy_reg        <= '0;
            base_x_reg    <= '0;
            base_y_reg    <= '0;
            den_reg       <= '0;
            rem_reg       <= '0;
            low_reg       <= '0;
            quo_reg       <= '0;
            sq_v_reg      <= '0;
            sq_res_reg    <= '0;
            sq_bit_reg    <= '0;
            e_reg         <= '0;
            e1_reg        <= '0;
            f_reg         <= '0;
            prod_x_reg    <= '0;
            prod_y_reg    <= '0;
            res_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && res_valid_reg)
            begin
                res_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (take)
                    begin
                        dx_reg <= dx;
                        dy_reg <= dy;
                        base_x_reg <= base_mid ? mid_x : sx;
                        base_y_reg <= base_mid ? mid_y : sy;
                        den_reg    <= two_ph ? half : dur;
                        // numerator t * 2^Q, top part preloaded into remainder
                        rem_reg <= 32'({t_sat, {Q{1'b0}}} >> emg_pkg::QW);
                        low_reg <= emg_pkg::QW'({t_sat, {Q{1'b0}}});
                        cnt_reg <= 5'(emg_pkg::QW);
                        if (cmd.kind == emg_pkg::KIND_PLAY)
                        begin
                            running_reg   <= 1'b1;
                            elapsed_reg   <= '0;
                            cur_x_reg     <= cfg.start_x;
                            cur_y_reg     <= cfg.start_y;
                            res_reg       <= {cfg.start_x, cfg.start_y, 1'b1, 1'b0};
                            res_valid_reg <= 1'b1;
                        end
                        else if (cmd.kind == emg_pkg::KIND_STOP)
                        begin
                            running_reg   <= 1'b0;
                            res_reg       <= {cur_x_reg, cur_y_reg, 1'b0, 1'b0};
                            res_valid_reg <= 1'b1;
                        end
                        else if (cmd.kind != emg_pkg::KIND_TICK || !running_reg)
                        begin
                            res_reg       <= {cur_x_reg, cur_y_reg, running_reg, 1'b0};
                            res_valid_reg <= 1'b1;
                        end
                        else if (ph1 && t_sat >= half)
                        begin
                            // snap to midpoint at half time
                            elapsed_reg <= half;
                            f_reg       <= '0;
                            state_reg   <= ST_MUL;
                        end
                        else if (ph1)
                        begin
                            elapsed_reg <= t_sat;
                            path_reg    <= PATH_PH1;
                            state_reg   <= ST_DIV;
                        end
                        else if (t_sat >= dur)
                        begin
                            // end of move
                            elapsed_reg   <= dur;
                            running_reg   <= 1'b0;
                            cur_x_reg     <= cfg.end_x;
                            cur_y_reg     <= cfg.end_y;
                            res_reg       <= {cfg.end_x, cfg.end_y, 1'b0, 1'b1};
                            res_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            elapsed_reg <= t_sat;
                            state_reg   <= (two_ph && half == 32'd0) ? ST_NEXT : ST_DIV;
                            unique case (cfg.curve_mode)
                                emg_pkg::MODE_LINEAR:   path_reg <= PATH_LIN;
                                emg_pkg::MODE_EASE_IN:  path_reg <= PATH_IN;
                                emg_pkg::MODE_EASE_OUT: path_reg <= PATH_OUT;
                                default:
                                begin
                                    path_reg <= PATH_PH2;
                                    if (half == 32'd0)
                                    begin
                                        // zero half time: ratio taken as one
                                        quo_reg <= Q_ONE;
                                    end
                                end
                            endcase
                        end
                    end
                end

                ST_DIV:
                begin
                    rem_reg <= trial_ge ? 32'(trial - {1'b0, den_reg}) : trial[31:0];
                    quo_reg <= {quo_reg[emg_pkg::QW-2:0], trial_ge};
                    low_reg <= low_reg << 1;
                    cnt_reg <= cnt_reg - 5'd1;
                    if (cnt_reg == 5'd1)
                    begin
                        state_reg <= ST_NEXT;
                    end
                end

                ST_NEXT:
                begin
                    sq_v_reg   <= {quo_reg, {Q{1'b0}}};
                    sq_res_reg <= '0;
                    sq_bit_reg <= BIT0;
                    cnt_reg    <= 5'(emg_pkg::SQ_STEPS);
                    unique case (path_reg)
                        PATH_LIN:
                        begin
                            f_reg     <= emg_pkg::FW'(quo_reg);
                            state_reg <= ST_MUL;
                        end
                        PATH_IN, PATH_PH1: state_reg <= ST_SQR;
                        default:           state_reg <= ST_SQRT;
                    endcase
                end

                ST_SQR:
                begin
                    if (path_reg == PATH_IN)
                        f_reg <= emg_pkg::FW'(sq_prod >> Q);
                    else
                        f_reg <= emg_pkg::FW'(sq_prod >> (Q + 1));
                    state_reg <= ST_MUL;
                end

                ST_SQRT:
                begin
                    if (cnt_reg == 5'd0)
                    begin
                        if (path_reg == PATH_OUT)
                        begin
                            f_reg     <= emg_pkg::FW'(s_val);
                            state_reg <= ST_MUL;
                        end
                        else
                        begin
                            e_reg     <= (s_val > S_ONE) ? s_val - S_ONE : '0;
                            state_reg <= ST_KMUL;
                        end
                    end
                    else
                    begin
                        if (sq_v_reg >= sq_sum)
                        begin
                            sq_v_reg   <= sq_v_reg - sq_sum;
                            sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                        end
                        else
                        begin
                            sq_res_reg <= sq_res_reg >> 1;
                        end
                        sq_bit_reg <= sq_bit_reg >> 2;
                        cnt_reg    <= cnt_reg - 5'd1;
                    end
                end

                ST_KMUL:
                begin
                    e1_reg    <= (emg_pkg::SQ_STEPS+2)'(k_prod >> Q);
                    state_reg <= ST_GMUL;
                end

                ST_GMUL:
                begin
                    f_reg     <= emg_pkg::FW'(g_prod >> emg_pkg::GAIN_FRAC);
                    state_reg <= ST_MUL;
                end

                ST_MUL:
                begin
                    if (cnt_reg != 5'd31)
                    begin
                        prod_x_reg <= PW'(dx_reg * $signed({1'b0, f_reg}));
                        prod_y_reg <= PW'(dy_reg * $signed({1'b0, f_reg}));
                        cnt_reg    <= 5'd31;
                    end
                    else
                    begin
                        cur_x_reg     <= sat32(sum_x);
                        cur_y_reg     <= sat32(sum_y);
                        res_reg       <= {sat32(sum_x), sat32(sum_y), 1'b1, 1'b0};
                        res_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end

                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/easing_motion_generator.sv
// Top level of the easing motion generator: registers, front end and engine.
//
//  channel   handshake            payload
//  ---------------------------------------------------------------
//  input     push / full          item   (operation, delta_us)
//  result    pop / empty          result (pos_x, pos_y, playing, finished)
//  config    psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// Play, stop, ignored and end-of-move beats finish in the idle state, and
// a midpoint snap goes straight to the multiply; curve ticks first run the
// 18-step divider, plus the 17-step square root for ease-out and phase two.
// Reset is asynchronous and active low; no clearing pass is needed.
// The two-beat front queue takes input while the engine works or a result
// waits; the engine starts a beat only once the result register is free.
module easing_motion_generator (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  emg_pkg::item_t   item,
    output logic             empty,
    input  logic             pop,
    output emg_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    emg_pkg::cfg_t cfg;
    emg_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_take;

    emg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // decode and queue input beats
    emg_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    // motion state and arithmetic, owns the result register
    emg_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .result    (result),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

>>> tb/easing_motion_generator_tb.sv
// Self-checking testbench for the easing motion generator: directed and random beats.
module easing_motion_generator_tb;

    // unused operation code, must be ignored by the block
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // ------------------------------------------------------------------
    // Clock, reset and DUT hookup
    // ------------------------------------------------------------------
    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             push = 1'b0;
    logic             full;
    emg_pkg::item_t   item = '0;
    logic             empty;
    logic             pop = 1'b0;
    emg_pkg::result_t result;
    logic             psel = 1'b0;
    logic             penable = 1'b0;
    logic             pwrite = 1'b0;
    logic [4:0]       paddr = '0;
    logic [31:0]      pwdata = '0;
    logic [31:0]      prdata;
    logic             pready;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    easing_motion_generator dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .full    (full),
        .item    (item),
        .empty   (empty),
        .pop     (pop),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Motion predictor: own copy of registers and state
    // ------------------------------------------------------------------
    longint      pr_start_x, pr_start_y, pr_end_x, pr_end_y;
    logic [31:0] pr_duration;
    logic [1:0]  pr_curve;
    logic [15:0] pr_gain;
    logic [31:0] pr_elapsed;
    logic        pr_running;
    longint      pr_cur_x, pr_cur_y;

    emg_pkg::result_t expected_motion_q[$];
    int               mismatch_count = 0;

    // Integer square root, bit-by-bit.
    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] root;
        logic [63:0] b;
        root = 0;
        b = 64'h1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= root + b)
            begin
                v = v - (root + b);
                root = (root >> 1) + b;
            end
            else
                root = root >> 1;
            b = b >> 2;
        end
        return root;
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // pos = base + floor(d*f / 2^Q); base is the midpoint at the half-time snap and in two-phase phase two.
    task automatic place_point(input longint f, input bit from_mid);
        longint dx, dy, bx, by;
        dx = pr_end_x - pr_start_x;
        dy = pr_end_y - pr_start_y;
        bx = pr_start_x;
        by = pr_start_y;
        if (from_mid)
        begin
            bx = pr_start_x + (dx >>> 1);
            by = pr_start_y + (dy >>> 1);
        end
        pr_cur_x = clamp32(bx + ((dx * f) >>> emg_pkg::FRAC_BITS));
        pr_cur_y = clamp32(by + ((dy * f) >>> emg_pkg::FRAC_BITS));
    endtask

    task automatic advance_motion(input emg_pkg::item_t it, output emg_pkg::result_t r);
        logic [63:0] T, h, t, q, p, s, e1;
        bit          phase_one;
        bit          done;
        done = 1'b0;
        if (it.operation == emg_pkg::OP_PLAY)
        begin
            pr_running = 1'b1;
            pr_elapsed = '0;
            pr_cur_x = pr_start_x;
            pr_cur_y = pr_start_y;
        end
        else if (it.operation == emg_pkg::OP_STOP)
            pr_running = 1'b0;
        else if (it.operation == emg_pkg::OP_TICK && pr_running)
        begin
            T = (pr_duration == 0) ? 64'd1 : {32'd0, pr_duration};
            h = T >> 1;
            t = {32'd0, pr_elapsed} + {32'd0, it.delta_us};
            phase_one = (pr_curve == emg_pkg::MODE_TWO_PH) && ({32'd0, pr_elapsed} < h);
            if (t > 64'hFFFF_FFFF)
                t = 64'hFFFF_FFFF;   // elapsed saturates
            if (phase_one && t >= h)
            begin
                // snap to midpoint, clamp elapsed to half time
                pr_elapsed = h[31:0];
                place_point(0, 1'b1);
            end
            else if (phase_one)
            begin
                p = (t << emg_pkg::FRAC_BITS) / h;
                pr_elapsed = t[31:0];
                place_point(longint'((p * p) >> (emg_pkg::FRAC_BITS + 1)), 1'b0);
            end
            else if (t >= T)
            begin
                // end of move: exact end point
                pr_elapsed = T[31:0];
                pr_cur_x = pr_end_x;
                pr_cur_y = pr_end_y;
                pr_running = 1'b0;
                done = 1'b1;
            end
            else
            begin
                q = (t << emg_pkg::FRAC_BITS) / T;
                pr_elapsed = t[31:0];
                case (pr_curve)
                    emg_pkg::MODE_LINEAR:
                        place_point(longint'(q), 1'b0);
                    emg_pkg::MODE_EASE_IN:
                        place_point(longint'((q * q) >> emg_pkg::FRAC_BITS), 1'b0);
                    emg_pkg::MODE_EASE_OUT:
                        place_point(longint'(int_sqrt(q << emg_pkg::FRAC_BITS)), 1'b0);
                    default:
                    begin
                        // half time zero: ratio pinned at one, stays at mid
                        p = (h != 0) ? (t << emg_pkg::FRAC_BITS) / h
                                     : (64'd1 << emg_pkg::FRAC_BITS);
                        s = int_sqrt(p << emg_pkg::FRAC_BITS);
                        e1 = (s > (64'd1 << emg_pkg::FRAC_BITS)) ?
                             s - (64'd1 << emg_pkg::FRAC_BITS) : 64'd0;
                        e1 = (e1 * emg_pkg::K_ONE_POINT_TWO) >> emg_pkg::FRAC_BITS;
                        e1 = (e1 * pr_gain) >> emg_pkg::GAIN_FRAC;
                        place_point(longint'(e1), 1'b1);
                    end
                endcase
            end
        end
        r.pos_x = pr_cur_x[31:0];
        r.pos_y = pr_cur_y[31:0];
        r.playing = pr_running;
        r.finished = done;
    endtask

    // ------------------------------------------------------------------
    // Bus-side tasks
    // ------------------------------------------------------------------

    // Waits until all predicted results have drained, then lets the engine settle.
    task automatic drain_results();
        while (expected_motion_q.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // Two-phase register write; only called with the block idle.
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            emg_pkg::REG_START_X:  pr_start_x = longint'(signed'(value));
            emg_pkg::REG_START_Y:  pr_start_y = longint'(signed'(value));
            emg_pkg::REG_END_X:    pr_end_x = longint'(signed'(value));
            emg_pkg::REG_END_Y:    pr_end_y = longint'(signed'(value));
            emg_pkg::REG_DURATION: pr_duration = value;
            emg_pkg::REG_CURVE:    pr_curve = value[1:0];
            default:               pr_gain = value[15:0];
        endcase
    endtask

    task automatic write_all(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] dur, input logic [1:0] mode,
                             input logic [15:0] gain);
        drain_results();
        write_reg(emg_pkg::REG_START_X, sx);
        write_reg(emg_pkg::REG_START_Y, sy);
        write_reg(emg_pkg::REG_END_X, ex);
        write_reg(emg_pkg::REG_END_Y, ey);
        write_reg(emg_pkg::REG_DURATION, dur);
        write_reg(emg_pkg::REG_CURVE, {30'd0, mode});
        write_reg(emg_pkg::REG_GAIN, {16'd0, gain});
    endtask

    // Sends one beat after a random gap. push stays high into a zero gap.
    task automatic send_beat(input logic [1:0] op, input logic [31:0] delta);
        int               gap;
        logic             was_full;
        emg_pkg::item_t   it;
        emg_pkg::result_t r;
        gap = $urandom_range(0, 12);
        if ($urandom_range(0, 3) == 0)
            gap = 0;                 // back-to-back stretches
        if (gap != 0 || !push)
        begin
            if (push)
                push <= 1'b0;
            repeat (gap) @(posedge clk);
            if (gap == 0)
                @(posedge clk);
        end
        it.operation = op;
        it.delta_us = delta;
        push <= 1'b1;
        item <= it;
        do
        begin
            @(negedge clk);
            was_full = full;
            @(posedge clk);
        end
        while (was_full);
        advance_motion(it, r);
        expected_motion_q = {expected_motion_q, r};
    endtask

    // Drops push right after the last accepting edge.
    task automatic end_send();
        push <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: random stalls on pop, compare against oldest prediction
    // ------------------------------------------------------------------
    initial
    begin : result_check
        int               stall;
        logic             was_empty;
        emg_pkg::result_t got;
        emg_pkg::result_t want;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 12);
            if ($urandom_range(0, 3) == 0)
                stall = 0;
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do
            begin
                @(negedge clk);
                was_empty = empty;
                got = result;
                @(posedge clk);
            end
            while (was_empty);
            if (expected_motion_q.size() == 0)
            begin
                $display("%0t unexpected result beat: expected none, actual %h", $time, got);
                mismatch_count++;
            end
            else
            begin
                want = expected_motion_q.pop_front();
                if (got.pos_x !== want.pos_x)
                begin
                    $display("%0t pos_x mismatch: expected %h actual %h",
                             $time, want.pos_x, got.pos_x);
                    mismatch_count++;
                end
                if (got.pos_y !== want.pos_y)
                begin
                    $display("%0t pos_y mismatch: expected %h actual %h",
                             $time, want.pos_y, got.pos_y);
                    mismatch_count++;
                end
                if (got.playing !== want.playing)
                begin
                    $display("%0t playing mismatch: expected %b actual %b",
                             $time, want.playing, got.playing);
                    mismatch_count++;
                end
                if (got.finished !== want.finished)
                begin
                    $display("%0t finished mismatch: expected %b actual %b",
                             $time, want.finished, got.finished);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset defaults, ignored beats, overflow, stop, extremes and short durations.
    task automatic test_directed();
        send_beat(emg_pkg::OP_TICK, 32'd500);          // tick while stopped
        send_beat(OP_UNUSED, 32'hFFFF_FFFF);           // unused op: ignored
        send_beat(emg_pkg::OP_PLAY, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd250000);
        send_beat(emg_pkg::OP_STOP, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd250000);       // held after stop
        send_beat(emg_pkg::OP_PLAY, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'hFFFF_FFFF);    // tick past the duration: move ends
        end_send();
        // widest span, two-phase with max gain: exercises saturation
        write_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                  32'd100, emg_pkg::MODE_TWO_PH, 16'hFFFF);
        send_beat(emg_pkg::OP_PLAY, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd20);
        send_beat(emg_pkg::OP_TICK, 32'd40);           // hits half time: snap to mid
        send_beat(emg_pkg::OP_TICK, 32'd30);
        send_beat(emg_pkg::OP_TICK, 32'd29);
        send_beat(emg_pkg::OP_TICK, 32'd1);            // tick after the move has ended
        end_send();
        // zero duration behaves as one; half time is zero
        write_all(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0000_0000,
                  32'd0, emg_pkg::MODE_TWO_PH, 16'd0);
        send_beat(emg_pkg::OP_PLAY, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'd1);
        end_send();
        write_all(32'h0001_0000, 32'hFFFF_0000, 32'h0005_0000, 32'h0000_0000,
                  32'hFFFF_FFFF, emg_pkg::MODE_EASE_OUT, 16'd4096);
        send_beat(emg_pkg::OP_PLAY, 32'd0);
        send_beat(emg_pkg::OP_TICK, 32'h4000_0000);
        send_beat(emg_pkg::OP_TICK, 32'h8000_0000);
        end_send();
    endtask

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(0, 3))
            0:       return $urandom;
            1:       return ($urandom_range(0, 1) != 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000;
        endcase
    endfunction

    function automatic logic [31:0] pick_duration();
        case ($urandom_range(0, 5))
            0:       return $urandom_range(0, 3);
            1:       return ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'd1000000;
            2:       return $urandom;
            default: return $urandom_range(4, 5000);
        endcase
    endfunction

    // Random registers per phase; mostly play-then-tick sequences with noise.
    task automatic test_random_moves(input int beats);
        int          sent;
        int          phase_len;
        logic [31:0] dur;
        logic [31:0] step_max;
        logic [31:0] delta;
        int          pick;
        sent = 0;
        while (sent < beats)
        begin
            dur = pick_duration();
            write_all(pick_coord(), pick_coord(), pick_coord(), pick_coord(), dur,
                      2'($urandom_range(0, 3)),
                      ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192)));
            step_max = dur / $urandom_range(2, 24);
            phase_len = $urandom_range(40, 80);
            repeat (phase_len)
            begin
                pick = $urandom_range(0, 99);
                delta = $urandom_range(0, step_max);
                if (pick < 8)
                    send_beat(emg_pkg::OP_PLAY, $urandom);
                else if (pick < 11)
                    send_beat(emg_pkg::OP_STOP, $urandom);
                else if (pick < 13)
                    send_beat(OP_UNUSED, $urandom);
                else if (pick < 16)
                    send_beat(emg_pkg::OP_TICK, $urandom);
                else if (pick < 17)
                    send_beat(emg_pkg::OP_TICK, 32'hFFFF_FFFF);
                else
                    send_beat(emg_pkg::OP_TICK, delta);
                sent++;
                // sender holds off until everything is back
                if (pick == 50)
                begin
                    end_send();
                    while (expected_motion_q.size() != 0)
                        @(posedge clk);
                end
            end
            end_send();
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        pr_start_x = 0;
        pr_start_y = 0;
        pr_end_x = 0;
        pr_end_y = 0;
        pr_duration = emg_pkg::DURATION_RST;
        pr_curve = emg_pkg::MODE_LINEAR;
        pr_gain = emg_pkg::GAIN_RST;
        pr_elapsed = '0;
        pr_running = 1'b0;
        pr_cur_x = 0;
        pr_cur_y = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_moves(1750);
        drain_results();
        if (mismatch_count == 0)
            $display("** easing_motion_generator: PASSED **");
        else
            $display("** easing_motion_generator: FAILED **");
        $finish;
    end

    initial
    begin
        #60000000;
        $display("** easing_motion_generator: FAILED **");
        $finish;
    end

endmodule
